[design/pict_pkg.sv]
// Shared types and constants for the point-in-cylinder test pipeline.
// Used by the top level and by the pipelined squaring unit.
package pict_pkg;

   // Register stages from the input word to the result register.
   localparam int NUM_STAGES = 8;

   // Width of the configuration register index.
   localparam int CSR_IDX_WIDTH = 3;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_START_X  = 3'd0,
      REG_START_Y  = 3'd1,
      REG_START_Z  = 3'd2,
      REG_END_X    = 3'd3,
      REG_END_Y    = 3'd4,
      REG_END_Z    = 3'd5,
      REG_RADIUS   = 3'd6,
      REG_AXIS_LEN = 3'd7
   } pict_reg_type;

   // Stage enables for the two register stages of a squaring unit.
   typedef struct packed {
      logic prod_en;
      logic sum_en;
   } pict_sq_ctl_type;

endpackage

[design/pict_square.sv]
// Two-stage pipelined squaring unit for a wide unsigned magnitude.
// Splits the operand into halves; depends on pict_pkg for the stage enables.
module pict_square
   import pict_pkg::*;
#(
   parameter int HALF_WIDTH = 33
) (
   input  logic                      clock,
   input  pict_sq_ctl_type           ctl,
   input  logic [2*HALF_WIDTH-1:0]   mag,
   output logic [4*HALF_WIDTH-1:0]   square
);

   localparam int H = HALF_WIDTH;

   logic [H-1:0]   mag_hi;
   logic [H-1:0]   mag_lo;
   logic [2*H-1:0] hh_in, hl_in, ll_in;
   logic [2*H-1:0] hh_ff, hl_ff, ll_ff;
   logic [4*H-1:0] square_in, square_ff;

   // Partial products of the two halves.
   assign mag_hi = mag[2*H-1:H];
   assign mag_lo = mag[H-1:0];
   assign hh_in  = mag_hi * mag_hi;
   assign hl_in  = mag_hi * mag_lo;
   assign ll_in  = mag_lo * mag_lo;

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         ll_ff <= ll_in;
      end
   end

   // The outer terms concatenate; the doubled cross term is the only add.
   assign square_in = {hh_ff, ll_ff} + {{(H-1){1'b0}}, hl_ff, {(H+1){1'b0}}};

   always_ff @(posedge clock) begin
      if (ctl.sum_en) begin
         square_ff <= square_in;
      end
   end

   assign square = square_ff;

endmodule

[design/point_in_cylinder_test.sv]
// Point-in-finite-cylinder test: one point and pad per word, one inside flag per word.
// Throughput is one word per cycle while the response channel does not stall, set by the
// eight-stage multiply, square and compare pipeline.
// Stalls collapse bubbles stage by stage, so the input keeps flowing while a result waits,
// until every stage holds a word; then the input stalls in the same cycle as the output.
// Synchronous reset empties the pipeline and returns the cylinder to a unit radius,
// unit length cylinder along z from the origin.
module point_in_cylinder_test
   import pict_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration write port
   input  logic                            csr_wr_en,
   input  logic [CSR_IDX_WIDTH-1:0]        csr_index,
   input  logic [COORD_WIDTH-1:0]          csr_wdata,
   // Request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [COORD_WIDTH-1:0]   req_point_x,
   input  logic signed [COORD_WIDTH-1:0]   req_point_y,
   input  logic signed [COORD_WIDTH-1:0]   req_point_z,
   input  logic signed [COORD_WIDTH-1:0]   req_pad,
   // Response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_inside_res
);

   localparam int CW   = COORD_WIDTH;
   localparam int LW   = CW - 1;          // radius and axis length
   localparam int DW   = CW + 1;          // coordinate differences
   localparam int PW   = 2 * DW;          // products of differences
   localparam int XW   = PW + 1;          // cross product components
   localparam int MW   = PW;              // magnitudes fed to the squarers
   localparam int SW   = 2 * MW;          // squares
   localparam int QW   = SW + 2;          // sum of three squares
   localparam int CMPW = PW + 2;          // axial comparison width
   localparam int LOW  = 2 * CW;          // length times pad
   localparam int HIW  = CW + DW;         // length times (length - pad)

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [CW-1:0] start_pt_ff [3];
   logic [CW-1:0] end_pt_ff   [3];
   logic [LW-1:0] radius_ff;
   logic [LW-1:0] axis_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_pt_ff[0] <= '0;
         start_pt_ff[1] <= '0;
         start_pt_ff[2] <= '0;
         end_pt_ff[0]   <= '0;
         end_pt_ff[1]   <= '0;
         end_pt_ff[2]   <= CW'(64'd1 << FRAC_BITS);
         radius_ff      <= LW'(64'd1 << FRAC_BITS);
         axis_len_ff    <= LW'(64'd1 << FRAC_BITS);
      end else if (csr_wr_en) begin
         unique case (pict_reg_type'(csr_index))
            REG_START_X:  start_pt_ff[0] <= csr_wdata;
            REG_START_Y:  start_pt_ff[1] <= csr_wdata;
            REG_START_Z:  start_pt_ff[2] <= csr_wdata;
            REG_END_X:    end_pt_ff[0]   <= csr_wdata;
            REG_END_Y:    end_pt_ff[1]   <= csr_wdata;
            REG_END_Z:    end_pt_ff[2]   <= csr_wdata;
            REG_RADIUS:   radius_ff      <= csr_wdata[LW-1:0];
            REG_AXIS_LEN: axis_len_ff    <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control: a stage loads when empty or when it drains.
   // ------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] en;

   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign valid_in = {valid_ff[NUM_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // ------------------------------------------------------------------
   // Stage 1: differences to the axis end points and shrunk extents.
   // ------------------------------------------------------------------
   logic [CW-1:0]        point [3];
   logic signed [DW-1:0] s1_a_in [3], s1_b_in [3], s1_c_in [3];
   logic signed [DW-1:0] s1_a_ff [3], s1_b_ff [3], s1_c_ff [3];
   logic signed [DW-1:0] s1_lmp_in, s1_lmp_ff;
   logic signed [DW-1:0] s1_rp_in, s1_rp_ff;
   logic signed [CW-1:0] s1_pad_ff;
   logic [LW-1:0]        s1_len_ff;
   logic                 s1_ok_in, s1_ok_ff;

   assign point[0] = req_point_x;
   assign point[1] = req_point_y;
   assign point[2] = req_point_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_a_in[i] = {point[i][CW-1], point[i]} - {start_pt_ff[i][CW-1], start_pt_ff[i]};
         s1_b_in[i] = {point[i][CW-1], point[i]} - {end_pt_ff[i][CW-1], end_pt_ff[i]};
         s1_c_in[i] = {end_pt_ff[i][CW-1], end_pt_ff[i]}
                    - {start_pt_ff[i][CW-1], start_pt_ff[i]};
      end
   end

   assign s1_lmp_in = {2'b00, axis_len_ff} - {req_pad[CW-1], req_pad};
   assign s1_rp_in  = {2'b00, radius_ff} - {req_pad[CW-1], req_pad};
   assign s1_ok_in  = (axis_len_ff != '0);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_a_ff   <= s1_a_in;
         s1_b_ff   <= s1_b_in;
         s1_c_ff   <= s1_c_in;
         s1_lmp_ff <= s1_lmp_in;
         s1_rp_ff  <= s1_rp_in;
         s1_pad_ff <= req_pad;
         s1_len_ff <= axis_len_ff;
         s1_ok_ff  <= s1_ok_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: all first-level products.
   // ------------------------------------------------------------------
   logic signed [PW-1:0]  s2_dot_in [3], s2_dot_ff [3];
   logic signed [PW-1:0]  s2_xp_in [6], s2_xp_ff [6];
   logic signed [CW-1:0]  s2_len_s;
   logic signed [LOW-1:0] s2_lo_in, s2_lo_ff;
   logic signed [HIW-1:0] s2_hi_in, s2_hi_ff;
   logic [MW-1:0]         s2_rl_in, s2_rl_ff;
   logic                  s2_ok_in, s2_ok_ff;

   assign s2_len_s = {1'b0, s1_len_ff};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_dot_in[i] = s1_a_ff[i] * s1_c_ff[i];
      end
   end

   // Cross product terms of A x B, taken in pairs later.
   assign s2_xp_in[0] = s1_a_ff[1] * s1_b_ff[2];
   assign s2_xp_in[1] = s1_a_ff[2] * s1_b_ff[1];
   assign s2_xp_in[2] = s1_a_ff[2] * s1_b_ff[0];
   assign s2_xp_in[3] = s1_a_ff[0] * s1_b_ff[2];
   assign s2_xp_in[4] = s1_a_ff[0] * s1_b_ff[1];
   assign s2_xp_in[5] = s1_a_ff[1] * s1_b_ff[0];

   assign s2_lo_in = s2_len_s * s1_pad_ff;
   assign s2_hi_in = s2_len_s * s1_lmp_ff;

   // Shrunk radius times length; only meaningful when the radius is not negative.
   assign s2_rl_in = s1_rp_ff[CW-1:0] * s1_len_ff;
   assign s2_ok_in = s1_ok_ff && !s1_rp_ff[DW-1];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_dot_ff <= s2_dot_in;
         s2_xp_ff  <= s2_xp_in;
         s2_lo_ff  <= s2_lo_in;
         s2_hi_ff  <= s2_hi_in;
         s2_rl_ff  <= s2_rl_in;
         s2_ok_ff  <= s2_ok_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: dot product sum and cross product components.
   // ------------------------------------------------------------------
   logic signed [CMPW-1:0] s3_dot_in, s3_dot_ff;
   logic signed [CMPW-1:0] s3_lo_in, s3_lo_ff;
   logic signed [CMPW-1:0] s3_hi_in, s3_hi_ff;
   logic signed [XW-1:0]   s3_cr_in [3], s3_cr_ff [3];
   logic [MW-1:0]          s3_rl_ff;
   logic                   s3_ok_ff;

   assign s3_dot_in = {{2{s2_dot_ff[0][PW-1]}}, s2_dot_ff[0]}
                    + {{2{s2_dot_ff[1][PW-1]}}, s2_dot_ff[1]}
                    + {{2{s2_dot_ff[2][PW-1]}}, s2_dot_ff[2]};

   assign s3_lo_in = {{(CMPW-LOW){s2_lo_ff[LOW-1]}}, s2_lo_ff};
   assign s3_hi_in = {{(CMPW-HIW){s2_hi_ff[HIW-1]}}, s2_hi_ff};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_cr_in[i] = {s2_xp_ff[2*i][PW-1], s2_xp_ff[2*i]}
                     - {s2_xp_ff[2*i+1][PW-1], s2_xp_ff[2*i+1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_dot_ff <= s3_dot_in;
         s3_lo_ff  <= s3_lo_in;
         s3_hi_ff  <= s3_hi_in;
         s3_cr_ff  <= s3_cr_in;
         s3_rl_ff  <= s2_rl_ff;
         s3_ok_ff  <= s2_ok_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: axial range check and cross product magnitudes.
   // ------------------------------------------------------------------
   logic [XW-1:0] s4_abs [3];
   logic [MW-1:0] s4_mag_in [4], s4_mag_ff [4];
   logic          s4_ok_in, s4_ok_ff;

   assign s4_ok_in = s3_ok_ff && !(s3_dot_ff < s3_lo_ff) && !(s3_hi_ff < s3_dot_ff);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_abs[i]    = s3_cr_ff[i][XW-1] ? (~s3_cr_ff[i] + 1'b1) : s3_cr_ff[i];
         s4_mag_in[i] = s4_abs[i][MW-1:0];
      end
      s4_mag_in[3] = s3_rl_ff;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s4_mag_ff <= s4_mag_in;
         s4_ok_ff  <= s4_ok_in;
      end
   end

   // ------------------------------------------------------------------
   // Stages 5 and 6: squares of the three cross components and of the
   // shrunk radius times length.
   // ------------------------------------------------------------------
   pict_sq_ctl_type sq_ctl;
   logic [SW-1:0]   sq [4];
   logic            s5_ok_ff, s6_ok_ff;

   assign sq_ctl.prod_en = en[4];
   assign sq_ctl.sum_en  = en[5];

   for (genvar g = 0; g < 4; g++) begin : g_square
      pict_square #(
         .HALF_WIDTH (DW)
      ) u_square (
         .clock  (clock),
         .ctl    (sq_ctl),
         .mag    (s4_mag_ff[g]),
         .square (sq[g])
      );
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_ok_ff <= s4_ok_ff;
      end
      if (en[5]) begin
         s6_ok_ff <= s5_ok_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: squared distance to the axis, scaled by length squared.
   // ------------------------------------------------------------------
   logic [QW-1:0] s7_q_in, s7_q_ff;
   logic [SW-1:0] s7_lim_ff;
   logic          s7_ok_ff;

   assign s7_q_in = QW'(sq[0]) + QW'(sq[1]) + QW'(sq[2]);

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s7_q_ff   <= s7_q_in;
         s7_lim_ff <= sq[3];
         s7_ok_ff  <= s6_ok_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 8: radial check and result register.
   // ------------------------------------------------------------------
   logic rsp_inside_in, rsp_inside_ff;

   assign rsp_inside_in = s7_ok_ff && !({2'b00, s7_lim_ff} < s7_q_ff);

   always_ff @(posedge clock) begin
      if (en[7]) begin
         rsp_inside_ff <= rsp_inside_in;
      end
   end

   assign rsp_inside_res = rsp_inside_ff;

endmodule
